/* rtl/core/bvg_pkg.sv */
// Shared widths, breakpoints, queue depths and result type for the battery voltage gauge.
package bvg_pkg;

   // Field widths
   localparam int MV_W  = 13;
   localparam int PCT_W = 7;

   // Defaults
   localparam int                WINDOW_DEPTH_DEF  = 16;
   localparam int                MID_DEPTH         = 4;
   localparam int                OUT_DEPTH         = 4;
   localparam logic [MV_W-1:0]   LOW_BATTERY_RESET = 13'd3400;

   // Discharge curve breakpoints in millivolts
   localparam logic [MV_W-1:0]   BP_FULL  = 13'd4150;
   localparam logic [MV_W-1:0]   BP_HIGH  = 13'd3750;
   localparam logic [MV_W-1:0]   BP_MID   = 13'd3650;
   localparam logic [MV_W-1:0]   BP_LOW   = 13'd3500;
   localparam logic [MV_W-1:0]   BP_EMPTY = 13'd3200;

   // Percent offsets at the full, high, mid and low breakpoints
   localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0]  PCT_HIGH = 7'd80;
   localparam logic [PCT_W-1:0]  PCT_MID  = 7'd20;
   localparam logic [PCT_W-1:0]  PCT_LOW  = 7'd10;

   typedef struct packed {
      logic [MV_W-1:0]  average_mv;
      logic [PCT_W-1:0] charge_percent;
      logic             low_battery;
   } result_type;

endpackage

/* rtl/core/battery_voltage_gauge.sv */
// Battery voltage gauge top level: window average, charge percent, low battery flag.
//
// Input queue port: drive req_sample_mv and raise req_push; the item is taken at an edge
// where req_full is low. One sample per cycle is sustained while req_full stays low; the
// registered running sum update in the front end sets that rate.
// Result queue port: while rsp_empty is low the oldest result sits on rsp_average_mv,
// rsp_charge_percent and rsp_low_battery; raise rsp_pop to take it.
// Result path: the edge that takes a sample reads the window; then the sum enters the sum
// queue, the reciprocal multiply is registered and the percent segment result enters the
// result queue, from which it reaches the result ports.
// Configuration: csr_low_battery_mv is written when csr_valid is high (csr_ready is
// always high). Write it only while no sample is in flight.
// Reset (synchronous, active high) clears the window position, wrap and priming state, the
// running sum, the held percent and both queues, and sets the threshold to 3400 mV. The
// first sample after reset primes the whole window, so its average equals that sample.
// When the receiver stalls, results collect in a four-entry queue; the front end keeps
// taking samples until the sum queue between the two halves fills, then raises req_full.
module battery_voltage_gauge #(
   parameter int WINDOW_DEPTH = bvg_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic [bvg_pkg::MV_W-1:0]   req_sample_mv,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [bvg_pkg::MV_W-1:0]   rsp_average_mv,
   output logic [bvg_pkg::PCT_W-1:0]  rsp_charge_percent,
   output logic                       rsp_low_battery,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bvg_pkg::MV_W-1:0]   csr_low_battery_mv
);

   localparam int SUM_W     = bvg_pkg::MV_W + $clog2(WINDOW_DEPTH);
   localparam int RES_W     = $bits(bvg_pkg::result_type);
   localparam int MID_CNT_W = $clog2(bvg_pkg::MID_DEPTH) + 1;
   localparam int OUT_CNT_W = $clog2(bvg_pkg::OUT_DEPTH) + 1;

   logic [bvg_pkg::MV_W-1:0] low_mv_ff;

   logic                  mid_push, mid_pop, mid_empty;
   logic [SUM_W-1:0]      mid_wr_data, mid_rd_data;
   logic [MID_CNT_W-1:0]  mid_count;

   logic                  out_push;
   bvg_pkg::result_type   out_wr_data, out_rd_data;
   logic [OUT_CNT_W-1:0]  out_count;

   // Threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_mv_ff <= bvg_pkg::LOW_BATTERY_RESET;
      end else if (csr_valid && csr_ready) begin
         low_mv_ff <= csr_low_battery_mv;
      end
   end

   bvg_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .Q_DEPTH      (bvg_pkg::MID_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_sample_mv (req_sample_mv),
      .req_full      (req_full),
      .mid_count     (mid_count),
      .mid_push      (mid_push),
      .mid_data      (mid_wr_data)
   );

   bvg_fifo #(
      .WIDTH (SUM_W),
      .DEPTH (bvg_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_data),
      .pop       (mid_pop),
      .pop_data  (mid_rd_data),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   bvg_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .OUT_DEPTH    (bvg_pkg::OUT_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .mid_empty      (mid_empty),
      .mid_data       (mid_rd_data),
      .mid_pop        (mid_pop),
      .out_count      (out_count),
      .out_push       (out_push),
      .out_data       (out_wr_data),
      .low_battery_mv (low_mv_ff)
   );

   bvg_fifo #(
      .WIDTH (RES_W),
      .DEPTH (bvg_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_data),
      .pop       (rsp_pop),
      .pop_data  (out_rd_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_average_mv     = out_rd_data.average_mv;
   assign rsp_charge_percent = out_rd_data.charge_percent;
   assign rsp_low_battery    = out_rd_data.low_battery;

endmodule

/* rtl/core/bvg_fifo.sv */
// Small register queue with occupancy count.
module bvg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   // Pop only what is there; the writer checks space before pushing
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

/* rtl/core/bvg_front.sv */
// Front end: accepts samples, keeps the sample window and its running sum.
module bvg_front #(
   parameter int WINDOW_DEPTH = bvg_pkg::WINDOW_DEPTH_DEF,
   parameter int Q_DEPTH      = bvg_pkg::MID_DEPTH
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_push,
   input  logic [bvg_pkg::MV_W-1:0]                         req_sample_mv,
   output logic                                             req_full,
   input  logic [$clog2(Q_DEPTH):0]                         mid_count,
   output logic                                             mid_push,
   output logic [bvg_pkg::MV_W+$clog2(WINDOW_DEPTH)-1:0]    mid_data
);

   localparam int MV_W   = bvg_pkg::MV_W;
   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = MV_W + SLOT_W;
   localparam int CNT_W  = $clog2(Q_DEPTH) + 1;

   logic [MV_W-1:0]   window_mem [WINDOW_DEPTH];

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              wrapped_ff, wrapped_in;
   logic              primed_ff;
   logic [MV_W-1:0]   first_sample_ff;

   logic              s1_valid_ff;
   logic [MV_W-1:0]   s1_sample_ff;
   logic              s1_first_ff;
   logic              s1_wrapped_ff;
   logic [MV_W-1:0]   rd_data_ff;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [MV_W-1:0]   leaving;
   logic [CNT_W:0]    pending;
   logic              accept;

   // Hold off while the queue plus the item in flight could fill it
   assign pending  = {1'b0, mid_count} + (CNT_W+1)'(s1_valid_ff);
   assign req_full = (pending >= (CNT_W+1)'(Q_DEPTH));
   assign accept   = req_push && !req_full;

   // Next write slot and wrap flag
   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         wrapped_ff  <= 1'b0;
         primed_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         wrapped_ff  <= wrapped_in;
         s1_valid_ff <= accept;
         if (accept) begin
            primed_ff <= 1'b1;
         end
      end
   end

   // Capture the priming sample
   always_ff @(posedge clock) begin
      if (reset) begin
         first_sample_ff <= '0;
      end else if (accept && !primed_ff) begin
         first_sample_ff <= req_sample_mv;
      end
   end

   // Read the outgoing entry and overwrite it in the same cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff         <= window_mem[slot_ff];
         window_mem[slot_ff] <= req_sample_mv;
      end
   end

   // Stage the item for the sum update
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff  <= req_sample_mv;
         s1_first_ff   <= !primed_ff;
         s1_wrapped_ff <= wrapped_ff;
      end
   end

   // Drop the leaving sample, add the new one; the first sample fills the window
   always_comb begin
      leaving = s1_wrapped_ff ? rd_data_ff : first_sample_ff;
      sum_in  = sum_ff;
      if (s1_valid_ff) begin
         if (s1_first_ff) begin
            sum_in = SUM_W'(SUM_W'(s1_sample_ff) * SUM_W'(WINDOW_DEPTH));
         end else begin
            sum_in = sum_ff - SUM_W'(leaving) + SUM_W'(s1_sample_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign mid_push = s1_valid_ff;
   assign mid_data = sum_in;

endmodule

/* rtl/core/bvg_back.sv */
// Back end: turns window sums into average, charge percent and low battery flag.
module bvg_back #(
   parameter int WINDOW_DEPTH = bvg_pkg::WINDOW_DEPTH_DEF,
   parameter int OUT_DEPTH    = bvg_pkg::OUT_DEPTH
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             mid_empty,
   input  logic [bvg_pkg::MV_W+$clog2(WINDOW_DEPTH)-1:0]    mid_data,
   output logic                                             mid_pop,
   input  logic [$clog2(OUT_DEPTH):0]                       out_count,
   output logic                                             out_push,
   output bvg_pkg::result_type                              out_data,
   input  logic [bvg_pkg::MV_W-1:0]                         low_battery_mv
);

   localparam int MV_W   = bvg_pkg::MV_W;
   localparam int PCT_W  = bvg_pkg::PCT_W;
   localparam int LOG_D  = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = MV_W + LOG_D;
   localparam int SHIFT  = SUM_W + LOG_D;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int CNT_W  = $clog2(OUT_DEPTH) + 1;
   // Rounded-up reciprocal; exact quotient for every sum below 2**SUM_W
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + longint'(WINDOW_DEPTH) - 64'd1) / longint'(WINDOW_DEPTH);
   localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_L);

   logic                b1_valid_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PCT_W-1:0]    held_ff, pct_in;
   logic [MV_W-1:0]     avg;
   logic [CNT_W:0]      pending;

   // Piecewise-linear charge estimate; each sloped segment divides by a constant reciprocal
   function automatic logic [PCT_W-1:0] percent_of(input logic [MV_W-1:0]  a,
                                                   input logic [PCT_W-1:0] prev);
      logic [8:0]       x_hi;
      logic [6:0]       x_mid;
      logic [7:0]       x_lo;
      logic [8:0]       x_bot;
      logic [18:0]      p_hi;
      logic [16:0]      p_mid;
      logic [16:0]      p_lo;
      logic [18:0]      p_bot;
      logic [PCT_W-1:0] pct;
      x_hi  = 9'(a - bvg_pkg::BP_HIGH);
      x_mid = 7'(a - bvg_pkg::BP_MID);
      x_lo  = 8'(a - bvg_pkg::BP_LOW);
      x_bot = 9'(a - bvg_pkg::BP_EMPTY);
      // divide by 20, by 5/3, by 15 and by 30
      p_hi  = 19'(x_hi) * 19'(820);
      p_mid = 17'(x_mid) * 17'(615);
      p_lo  = 17'(x_lo) * 17'(274);
      p_bot = 19'(x_bot) * 19'(547);
      priority if (a >= bvg_pkg::BP_FULL) begin
         pct = bvg_pkg::PCT_FULL;
      end else if (a > bvg_pkg::BP_HIGH) begin
         pct = bvg_pkg::PCT_HIGH + PCT_W'(p_hi >> 14);
      end else if (a > bvg_pkg::BP_MID) begin
         pct = bvg_pkg::PCT_MID + PCT_W'(p_mid >> 10);
      end else if (a > bvg_pkg::BP_LOW) begin
         pct = bvg_pkg::PCT_LOW + PCT_W'(p_lo >> 12);
      end else if (a > bvg_pkg::BP_EMPTY) begin
         pct = PCT_W'(p_bot >> 14);
      end else begin
         pct = prev;
      end
      return pct;
   endfunction

   // Take a sum only when the result queue has room for everything in flight
   assign pending = {1'b0, out_count} + (CNT_W+1)'(b1_valid_ff);
   assign mid_pop = !mid_empty && (pending < (CNT_W+1)'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
      end
   end

   // Multiply by the reciprocal of the window depth
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         prod_ff <= PROD_W'(mid_data) * PROD_W'(RECIP);
      end
   end

   assign avg    = MV_W'(prod_ff >> SHIFT);
   assign pct_in = percent_of(avg, held_ff);

   // Hold the last percent for the low-voltage segment
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (b1_valid_ff) begin
         held_ff <= pct_in;
      end
   end

   assign out_push                = b1_valid_ff;
   assign out_data.average_mv     = avg;
   assign out_data.charge_percent = pct_in;
   assign out_data.low_battery    = (avg < low_battery_mv);

endmodule

/* rtl/core/bvg_checker.sv */
// Port-level checks for the battery voltage gauge, bound to the top level.
module bvg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [bvg_pkg::MV_W-1:0]   rsp_average_mv,
   input logic [bvg_pkg::PCT_W-1:0]  rsp_charge_percent,
   input logic                       rsp_low_battery,
   input logic                       csr_valid,
   input logic                       csr_ready
);

   // Reset leaves no result waiting and the input open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

   // Percent never exceeds full charge
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_charge_percent <= bvg_pkg::PCT_FULL))
      else $error("charge percent above full");

   // A full-charge average reports full charge
   a_pct_full: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_average_mv >= bvg_pkg::BP_FULL))
         |-> (rsp_charge_percent == bvg_pkg::PCT_FULL))
      else $error("full-charge average without full percent");

   // Threshold writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("threshold write stalled");

   // A waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!rsp_empty && !rsp_pop) && !$past(reset))
         |-> (!rsp_empty && $stable(rsp_average_mv) && $stable(rsp_charge_percent)
              && $stable(rsp_low_battery)))
      else $error("waiting result changed");

endmodule

bind battery_voltage_gauge bvg_checker u_bvg_checker (.*);
